// ===== design/rar_pkg.sv =====
package rar_pkg;

  // Request codes carried on req_type
  localparam logic [2:0] OP_REDUCE = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_SUB    = 3'd2;
  localparam logic [2:0] OP_MUL    = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;

  // Which product the shared multiplier forms this cycle
  typedef enum logic [1:0] {
    MUL_CROSS1 = 2'd0,
    MUL_CROSS2 = 2'd1,
    MUL_DEN    = 2'd2
  } mul_sel_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic     load;
    logic     mul;
    mul_sel_e mul_sel;
    logic     comb;
    logic     sel_two;
    logic     gcd_step;
    logic     div_init;
    logic     div_step;
    logic     emit;
    logic     last;
  } rar_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic special;
    logic gcd_done;
    logic div_last;
  } rar_sts_t;

endpackage

// ===== design/rar_ctrl.sv =====
module rar_ctrl
  import rar_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] req_type_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rar_cmd_t   cmd_o,
  input  rar_sts_t   sts_i
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL0  = 9'b000000010,
    S_MUL1  = 9'b000000100,
    S_MUL2  = 9'b000001000,
    S_COMB  = 9'b000010000,
    S_GCD   = 9'b000100000,
    S_DINIT = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_e;

  state_e   state_q, state_d;
  logic     reduce_q, reduce_d;
  logic     sel_two_q, sel_two_d;
  logic     out_valid_q, out_valid_d;
  logic     out_free;
  rar_cmd_t cmd;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // Run a request via the multiply, combine, GCD, divide, emit it needs
  always_comb begin
    state_d   = state_q;
    reduce_d  = reduce_q;
    sel_two_d = sel_two_q;
    cmd          = '0;
    cmd.mul_sel  = MUL_CROSS1;
    cmd.sel_two  = sel_two_q;
    cmd.last     = !(reduce_q && !sel_two_q);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load  = 1'b1;
          reduce_d  = (req_type_i == OP_REDUCE);
          sel_two_d = 1'b0;
          if (req_type_i == OP_REDUCE) begin
            state_d = S_COMB;
          end else if (req_type_i == OP_ADD || req_type_i == OP_SUB ||
                       req_type_i == OP_MUL || req_type_i == OP_DIV) begin
            state_d = S_MUL0;
          end
        end
      end
      S_MUL0: begin
        cmd.mul     = 1'b1;
        cmd.mul_sel = MUL_CROSS1;
        state_d     = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul     = 1'b1;
        cmd.mul_sel = MUL_CROSS2;
        state_d     = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul     = 1'b1;
        cmd.mul_sel = MUL_DEN;
        state_d     = S_COMB;
      end
      S_COMB: begin
        cmd.comb = 1'b1;
        state_d  = S_GCD;
      end
      S_GCD: begin
        priority if (sts_i.special) begin
          state_d = S_EMIT;
        end else if (sts_i.gcd_done) begin
          state_d = S_DINIT;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_d      = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          if (reduce_q && !sel_two_q) begin
            sel_two_d = 1'b1;
            state_d   = S_COMB;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold a result until the consumer takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      reduce_q    <= 1'b0;
      sel_two_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      reduce_q    <= reduce_d;
      sel_two_q   <= sel_two_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result emitted over an untaken result");

  a_reduce_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && !cmd.last) |=> (state_q == S_COMB && sel_two_q))
    else $error("second reduce fraction not started");
`endif

endmodule

// ===== design/rar_dpath.sv =====
module rar_dpath
  import rar_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rar_cmd_t                  cmd_i,
  output rar_sts_t                  sts_o,
  input  logic [2:0]                req_type_i,
  input  logic signed [WIDTH-1:0]   num_one_i,
  input  logic signed [WIDTH-1:0]   den_one_i,
  input  logic signed [WIDTH-1:0]   num_two_i,
  input  logic signed [WIDTH-1:0]   den_two_i,
  output logic signed [2*WIDTH:0]   res_num_o,
  output logic [2*WIDTH-2:0]        res_den_o,
  output logic                      status_o,
  output logic                      last_o
);

  localparam int PW = 2 * WIDTH;
  localparam int CW = $clog2(PW);

  function automatic logic [WIDTH-1:0] mag_of(input logic [WIDTH-1:0] v);
    return v[WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  // Captured request
  logic [2:0]       op_q;
  logic             sa1_q, sb1_q, sa2_q, sb2_q;
  logic [WIDTH-1:0] ma1_q, mb1_q, ma2_q, mb2_q;

  // Products and combined fraction
  logic [PW-1:0]    p1_q, p2_q, pd_q;
  logic [WIDTH-1:0] mul_a, mul_b;
  logic [PW-1:0]    prod;
  logic [PW-1:0]    nm_q, dm_q, nm_c, dm_c;
  logic             nneg_q, dneg_q, err_q, nneg_c, dneg_c, err_c;
  logic             s1, s2;

  // Binary GCD and divider lanes
  logic [PW-1:0]    ga_q, gb_q, ga_d, gb_d;
  logic [CW-1:0]    gk_q, gk_d;
  logic [PW-1:0]    g_q, rn_q, rd_q, rn_d, rd_d;
  logic [PW:0]      tn, td;
  logic             qn_bit, qd_bit;
  logic [CW-1:0]    cnt_q;

  // Result register
  logic [PW:0]      nm_ext;
  logic [PW:0]      res_num_q, res_num_d;
  logic [PW-2:0]    res_den_q, res_den_d;
  logic             status_q, last_q;

  // Pick operands of the shared multiplier
  always_comb begin
    mul_a = ma1_q;
    mul_b = mb2_q;
    unique case (cmd_i.mul_sel)
      MUL_CROSS1: begin
        mul_a = ma1_q;
        mul_b = (op_q == OP_MUL) ? ma2_q : mb2_q;
      end
      MUL_CROSS2: begin
        mul_a = ma2_q;
        mul_b = mb1_q;
      end
      MUL_DEN: begin
        mul_a = mb1_q;
        mul_b = (op_q == OP_DIV) ? ma2_q : mb2_q;
      end
      default: begin
        mul_a = ma1_q;
        mul_b = mb2_q;
      end
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  // Combine products into a signed fraction, or pick a reduce input
  always_comb begin
    s1     = sa1_q ^ sb2_q;
    s2     = sa2_q ^ sb1_q ^ (op_q == OP_SUB);
    nm_c   = p1_q;
    dm_c   = pd_q;
    nneg_c = 1'b0;
    dneg_c = sb1_q ^ sb2_q;
    err_c  = (mb1_q == '0) || (mb2_q == '0);
    if (op_q == OP_REDUCE) begin
      nm_c   = cmd_i.sel_two ? PW'(ma2_q) : PW'(ma1_q);
      dm_c   = cmd_i.sel_two ? PW'(mb2_q) : PW'(mb1_q);
      nneg_c = cmd_i.sel_two ? sa2_q : sa1_q;
      dneg_c = cmd_i.sel_two ? sb2_q : sb1_q;
      err_c  = 1'b0;
    end else if (op_q == OP_ADD || op_q == OP_SUB) begin
      priority if (s1 == s2) begin
        nm_c   = p1_q + p2_q;
        nneg_c = s1;
      end else if (p1_q >= p2_q) begin
        nm_c   = p1_q - p2_q;
        nneg_c = s1;
      end else begin
        nm_c   = p2_q - p1_q;
        nneg_c = s2;
      end
    end else if (op_q == OP_MUL) begin
      nneg_c = sa1_q ^ sa2_q;
    end else begin
      nneg_c = sa1_q ^ sb2_q;
      dneg_c = sb1_q ^ sa2_q;
      err_c  = err_c || (ma2_q == '0);
    end
    err_c = err_c || (dm_c == '0);
  end

  // Binary GCD step: halve even operand(s), or subtract and halve
  always_comb begin
    ga_d = ga_q;
    gb_d = gb_q;
    gk_d = gk_q;
    priority if (!ga_q[0] && !gb_q[0]) begin
      ga_d = ga_q >> 1;
      gb_d = gb_q >> 1;
      gk_d = gk_q + 1'b1;
    end else if (!ga_q[0]) begin
      ga_d = ga_q >> 1;
    end else if (!gb_q[0]) begin
      gb_d = gb_q >> 1;
    end else if (ga_q > gb_q) begin
      ga_d = (ga_q - gb_q) >> 1;
    end else begin
      gb_d = (gb_q - ga_q) >> 1;
    end
  end

  // Restoring divide step on both lanes by the common divisor
  always_comb begin
    tn     = {rn_q, nm_q[PW-1]};
    td     = {rd_q, dm_q[PW-1]};
    qn_bit = (tn >= {1'b0, g_q});
    qd_bit = (td >= {1'b0, g_q});
    rn_d   = qn_bit ? PW'(tn - {1'b0, g_q}) : tn[PW-1:0];
    rd_d   = qd_bit ? PW'(td - {1'b0, g_q}) : td[PW-1:0];
  end

  // Form the output fraction
  always_comb begin
    nm_ext    = {1'b0, nm_q};
    res_num_d = (nneg_q ^ dneg_q) ? (~nm_ext + 1'b1) : nm_ext;
    res_den_d = dm_q[PW-2:0];
    if (err_q) begin
      res_num_d = '0;
      res_den_d = '0;
    end else if (nm_q == '0) begin
      res_num_d = '0;
      res_den_d = (PW-1)'(1);
    end
  end

  assign sts_o.special  = err_q || (nm_q == '0);
  assign sts_o.gcd_done = (ga_q == gb_q);
  assign sts_o.div_last = (cnt_q == CW'(PW - 1));

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= req_type_i;
      sa1_q <= num_one_i[WIDTH-1];
      sb1_q <= den_one_i[WIDTH-1];
      sa2_q <= num_two_i[WIDTH-1];
      sb2_q <= den_two_i[WIDTH-1];
      ma1_q <= mag_of(num_one_i);
      mb1_q <= mag_of(den_one_i);
      ma2_q <= mag_of(num_two_i);
      mb2_q <= mag_of(den_two_i);
    end
    if (cmd_i.mul) begin
      unique case (cmd_i.mul_sel)
        MUL_CROSS1: p1_q <= prod;
        MUL_CROSS2: p2_q <= prod;
        MUL_DEN:    pd_q <= prod;
        default:    pd_q <= prod;
      endcase
    end
    if (cmd_i.comb) begin
      nm_q   <= nm_c;
      dm_q   <= dm_c;
      nneg_q <= nneg_c;
      dneg_q <= dneg_c;
      err_q  <= err_c;
      ga_q   <= nm_c;
      gb_q   <= dm_c;
      gk_q   <= '0;
    end else if (cmd_i.gcd_step) begin
      ga_q <= ga_d;
      gb_q <= gb_d;
      gk_q <= gk_d;
    end
    if (cmd_i.div_init) begin
      g_q  <= ga_q << gk_q;
      rn_q <= '0;
      rd_q <= '0;
    end else if (cmd_i.div_step) begin
      rn_q <= rn_d;
      rd_q <= rd_d;
      nm_q <= {nm_q[PW-2:0], qn_bit};
      dm_q <= {dm_q[PW-2:0], qd_bit};
    end
    if (cmd_i.emit) begin
      res_num_q <= res_num_d;
      res_den_q <= res_den_d;
      status_q  <= err_q;
      last_q    <= cmd_i.last;
    end
  end

  // Count divide steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign res_num_o = $signed(res_num_q);
  assign res_den_o = res_den_q;
  assign status_o  = status_q;
  assign last_o    = last_q;

`ifndef SYNTHESIS
  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gcd_step |-> (ga_q != '0 && gb_q != '0))
    else $error("GCD stepped on a zero operand");

  a_div_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_init |-> (!err_q && nm_q != '0 && ga_q == gb_q))
    else $error("divide started on an unreduced or special fraction");
`endif

endmodule

// ===== design/rational_arith_reduce.sv =====
// Channel   Direction  Handshake                Payload
// request   in         in_valid_i / in_stall_o  req_type_i, num_one_i, den_one_i,
//                                               num_two_i, den_two_i
// result    out        out_valid_o / out_stall_i res_num_o, res_den_o, status_o, last_o
//
// One request at a time. Add, subtract, multiply and divide form three products
// on the shared multiplier, then run the binary GCD steps (data dependent)
// and the bit-serial divider. Reduce runs the GCD and divide pass once per
// fraction. A zero numerator or an error skips the GCD and divider. Reset
// clears the sequencer and the divide step counter; a stalled result is held
// while the next one is computed.
module rational_arith_reduce
  import rar_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                req_type_i,
  input  logic signed [WIDTH-1:0]   num_one_i,
  input  logic signed [WIDTH-1:0]   den_one_i,
  input  logic signed [WIDTH-1:0]   num_two_i,
  input  logic signed [WIDTH-1:0]   den_two_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [2*WIDTH:0]   res_num_o,
  output logic [2*WIDTH-2:0]        res_den_o,
  output logic                      status_o,
  output logic                      last_o
);

  rar_cmd_t cmd;
  rar_sts_t sts;

  // Sequencer
  rar_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Multiplier, GCD and divider datapath
  rar_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .req_type_i (req_type_i),
    .num_one_i  (num_one_i),
    .den_one_i  (den_one_i),
    .num_two_i  (num_two_i),
    .den_two_i  (den_two_i),
    .res_num_o  (res_num_o),
    .res_den_o  (res_den_o),
    .status_o   (status_o),
    .last_o     (last_o)
  );

endmodule
